>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> rtl/essg_pkg.sv
// shared constants, register codes and sine table function for the sweep generator
package essg_pkg;

    localparam int PHASE_BITS_DEF  = 32;
    localparam int TABLE_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 24;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int START_BITS     = 31;
    localparam int RATIO_BITS     = 32;
    localparam int COUNT_REG_BITS = 24;

    localparam logic [START_BITS-1:0]     START_INCREMENT_RESET = '0;
    localparam logic [RATIO_BITS-1:0]     GROWTH_RATIO_RESET    = 32'h8000_0000;
    localparam logic [COUNT_REG_BITS-1:0] SAMPLE_COUNT_RESET    = 24'd48000;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1 <<< 30;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_START_INCREMENT = 2'd0,
        CFG_GROWTH_RATIO    = 2'd1,
        CFG_SAMPLE_COUNT    = 2'd2
    } cfg_index_t;

    // quarter-wave entry k: q30 taylor series of sin, scaled to full amplitude
    function automatic longint quarter_sine(longint k, int table_bits, int sample_bits);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint amp;
        longint v;
        amp  = (64'sd1 <<< (sample_bits - 1)) - 64'sd1;
        x    = (k * HALF_PI_Q30) >>> table_bits;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >>> 30) / 6;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >>> 30) / 42;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >>> 30) / 110;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 156;
        sum  = sum + term;
        if (sum < 0)
            sum = 0;
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        v = (sum * amp + (ONE_Q30 / 2)) >>> 30;
        if (v > amp)
            v = amp;
        return v;
    endfunction

endpackage

>>> rtl/essg_sine_rom.sv
// quarter-wave sine rom with registered read
module essg_sine_rom #(
    parameter int TABLE_BITS  = essg_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = essg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [TABLE_BITS:0]    rd_addr,
    output logic [SAMPLE_BITS-2:0] rd_data
);

    localparam int ENTRIES  = (1 << TABLE_BITS) + 1;
    localparam int AMP_BITS = SAMPLE_BITS - 1;

    logic [AMP_BITS-1:0] rom_mem [ENTRIES];
    logic [AMP_BITS-1:0] rd_data_reg;

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_entry
        assign rom_mem[k] =
            AMP_BITS'(essg_pkg::quarter_sine(longint'(k), TABLE_BITS, SAMPLE_BITS));
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/exponential_sine_sweep_generator.sv
// top level of the exponential sine sweep generator
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  in      | in_valid / in_stall      | restart
//  out     | out_valid / out_stall    | sample, last_sample, active
//  cfg     | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// one beat per cycle in and out while out_stall is low; an input beat reaches its result through
// the phase and address stage, the rom read register and the output register.
// the step recurrence (two partial products, round, saturate) is combinational into step_reg.
// rst_n is asynchronous; no clearing pass, the sine table is constant.
// out_stall holds the output register; in_stall rises only when all three stages hold data.
module exponential_sine_sweep_generator #(
    parameter int PHASE_BITS  = essg_pkg::PHASE_BITS_DEF,
    parameter int TABLE_BITS  = essg_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = essg_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = essg_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  restart,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]         sample,
    output logic                                  last_sample,
    output logic                                  active,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [essg_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [essg_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int PROD_BITS  = PHASE_BITS + essg_pkg::RATIO_BITS;
    localparam int ROUND_BITS = 49;
    localparam int GROW_BITS  = PROD_BITS - 14;
    localparam int ADDR_BITS  = TABLE_BITS + 1;
    localparam int SHIFT      = PHASE_BITS - TABLE_BITS - 2;
    localparam logic [ADDR_BITS-1:0] QUARTER = ADDR_BITS'(1) << TABLE_BITS;

    // configuration registers
    logic [essg_pkg::START_BITS-1:0] start_reg;
    logic [essg_pkg::RATIO_BITS-1:0] ratio_reg;
    logic [COUNT_BITS-1:0]           count_reg;

    // sweep state
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic [PHASE_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0] step_next;
    logic [COUNT_BITS-1:0] index_reg;
    logic [COUNT_BITS-1:0] index_next;
    logic                  running_reg;
    logic                  running_next;

    // pipeline
    logic                  s1_valid_reg;
    logic [ADDR_BITS-1:0]  s1_addr_reg;
    logic                  s1_neg_reg;
    logic                  s1_active_reg;
    logic                  s1_last_reg;
    logic                  s2_valid_reg;
    logic                  s2_neg_reg;
    logic                  s2_active_reg;
    logic                  s2_last_reg;
    logic [SAMPLE_BITS-2:0] s2_mag;
    logic                  out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] sample_next;
    logic                  last_reg;
    logic                  active_reg;

    logic s3_free;
    logic s2_free;
    logic s1_free;
    logic load3;
    logic load2;
    logic accept;

    logic [PHASE_BITS-1:0] start_scaled;
    logic [PHASE_BITS-1:0] phase_eff;
    logic [PHASE_BITS-1:0] step_eff;
    logic [COUNT_BITS-1:0] index_eff;
    logic                  run_eff;
    logic                  emit;
    logic [COUNT_BITS:0]   index_inc;
    logic                  is_last;

    logic [PHASE_BITS-1:0] step_hi;
    logic [PROD_BITS-1:0]  prod_hi;
    logic [47:0]           prod_lo;
    logic [ROUND_BITS-1:0] low_sum;
    logic [GROW_BITS-1:0]  grown;
    logic [PHASE_BITS-1:0] grown_sat;

    logic [TABLE_BITS+1:0] phase_top;
    logic [TABLE_BITS-1:0] table_idx;
    logic [ADDR_BITS-1:0]  table_addr;

    // flow control: each stage advances when the one after it can take data
    assign s3_free  = !out_valid_reg || !out_stall;
    assign load3    = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s3_free;
    assign load2    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_stall = !s1_free;
    assign accept   = in_valid && s1_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= essg_pkg::START_INCREMENT_RESET;
            ratio_reg <= essg_pkg::GROWTH_RATIO_RESET;
            count_reg <= COUNT_BITS'(essg_pkg::SAMPLE_COUNT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (essg_pkg::cfg_index_t'(cfg_index))
                essg_pkg::CFG_START_INCREMENT:
                    start_reg <= cfg_data[essg_pkg::START_BITS-1:0];
                essg_pkg::CFG_GROWTH_RATIO:
                    ratio_reg <= cfg_data;
                essg_pkg::CFG_SAMPLE_COUNT:
                    count_reg <= COUNT_BITS'(cfg_data[essg_pkg::COUNT_REG_BITS-1:0]);
                default:
                begin
                end
            endcase
        end
    end

    // start increment is q0.32, rescaled to the accumulator width
    if (PHASE_BITS >= 32)
    begin : g_start_up
        assign start_scaled = PHASE_BITS'({1'b0, start_reg}) << (PHASE_BITS - 32);
    end
    else
    begin : g_start_down
        assign start_scaled = PHASE_BITS'({1'b0, start_reg} >> (32 - PHASE_BITS));
    end

    assign phase_eff = restart ? '0 : phase_reg;
    assign step_eff  = restart ? start_scaled : step_reg;
    assign index_eff = restart ? '0 : index_reg;
    assign run_eff   = restart || running_reg;
    assign emit      = run_eff && (index_eff < count_reg);
    assign index_inc = {1'b0, index_eff} + (COUNT_BITS + 1)'(1);
    assign is_last   = (index_inc == {1'b0, count_reg});

    // step * ratio / 2^31 rounded half up, split into 16-bit low and high halves
    assign step_hi   = step_eff >> 16;
    assign prod_hi   = PROD_BITS'(step_hi) * PROD_BITS'(ratio_reg);
    assign prod_lo   = 48'(step_eff[15:0]) * 48'(ratio_reg);
    assign low_sum   = ROUND_BITS'({prod_hi[14:0], 16'b0}) + ROUND_BITS'(prod_lo)
                     + (ROUND_BITS'(1) << 30);
    assign grown     = GROW_BITS'(prod_hi >> 15) + GROW_BITS'(low_sum[ROUND_BITS-1:31]);
    assign grown_sat = (|grown[GROW_BITS-1:PHASE_BITS]) ? '1 : grown[PHASE_BITS-1:0];

    always_comb
    begin
        phase_next   = phase_eff;
        step_next    = step_eff;
        index_next   = index_eff;
        running_next = 1'b0;
        if (emit)
        begin
            phase_next   = phase_eff + step_eff;
            step_next    = grown_sat;
            index_next   = index_inc[COUNT_BITS-1:0];
            running_next = !is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            step_reg    <= '0;
            index_reg   <= '0;
            running_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            step_reg    <= step_next;
            index_reg   <= index_next;
            running_reg <= running_next;
        end
    end

    // quadrant from the top two phase bits, mirrored index in odd quadrants
    assign phase_top  = phase_eff[PHASE_BITS-1:SHIFT];
    assign table_idx  = phase_top[TABLE_BITS-1:0];
    assign table_addr = phase_top[TABLE_BITS] ? (QUARTER - ADDR_BITS'(table_idx))
                                              : ADDR_BITS'(table_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept || (s1_valid_reg && !s2_free);
            s2_valid_reg  <= load2 || (s2_valid_reg && !s3_free);
            out_valid_reg <= load3 || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg   <= table_addr;
            s1_neg_reg    <= phase_top[TABLE_BITS+1];
            s1_active_reg <= emit;
            s1_last_reg   <= emit && is_last;
        end
        if (load2)
        begin
            s2_neg_reg    <= s1_neg_reg;
            s2_active_reg <= s1_active_reg;
            s2_last_reg   <= s1_last_reg;
        end
        if (load3)
        begin
            sample_reg <= sample_next;
            last_reg   <= s2_last_reg;
            active_reg <= s2_active_reg;
        end
    end

    essg_sine_rom #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sine_rom (
        .clk     (clk),
        .rd_en   (load2),
        .rd_addr (s1_addr_reg),
        .rd_data (s2_mag)
    );

    always_comb
    begin
        sample_next = '0;
        if (s2_active_reg)
        begin
            sample_next = s2_neg_reg ? -{1'b0, s2_mag} : {1'b0, s2_mag};
        end
    end

    assign out_valid   = out_valid_reg;
    assign sample      = sample_reg;
    assign last_sample = last_reg;
    assign active      = active_reg;

endmodule

>>> rtl/essg_checker.sv
// port-level checks for the sweep generator, bound to the top level
`include "assert_macros.svh"

module essg_checker #(
    parameter int SAMPLE_BITS = essg_pkg::SAMPLE_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic signed [SAMPLE_BITS-1:0] sample,
    input logic                          last_sample,
    input logic                          active
);

    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // idle beats carry a zero sample and no end mark
    `ASSERT_IMPLY(a_idle_is_quiet, clk, rst_n, out_valid && !active, sample == '0 && !last_sample)

    `ASSERT_IMPLY(a_last_is_active, clk, rst_n, out_valid && last_sample, active)

    // amplitude is symmetric, the most negative code never shows
    `ASSERT_IMPLY(a_sample_in_range, clk, rst_n, out_valid, sample != MOST_NEG)

    `ASSERT_NEXT(a_stall_holds, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(sample) && $stable(last_sample) && $stable(active))

endmodule

bind exponential_sine_sweep_generator essg_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_essg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample      (sample),
    .last_sample (last_sample),
    .active      (active)
);
